// ===== hw/rtl/baro_temp_pressure_compensation_assert.svh =====
// Assertion macros for the barometric compensation block.
`ifndef BARO_TEMP_PRESSURE_COMPENSATION_ASSERT_SVH
`define BARO_TEMP_PRESSURE_COMPENSATION_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define BTPC_ASSERT_NOW(lbl, ant, con) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
        else $error("btpc assertion failed");
`define BTPC_ASSERT_NEXT(lbl, ant, con) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
        else $error("btpc assertion failed");
`else
`define BTPC_ASSERT_NOW(lbl, ant, con)
`define BTPC_ASSERT_NEXT(lbl, ant, con)
`endif
`endif

// ===== hw/rtl/btpc_pkg.sv =====
// Shared types, register indexes and helpers for the compensation block.
package btpc_pkg;

    typedef logic [63:0] word64_t;
    typedef logic [31:0] word32_t;

    // Configuration register indexes.
    localparam logic [1:0] CFG_TEMP_CAL       = 2'd0;
    localparam logic [1:0] CFG_PRESS_CAL_LOW  = 2'd1;
    localparam logic [1:0] CFG_PRESS_CAL_HIGH = 2'd2;
    localparam logic [1:0] CFG_PRESS_CAL_LAST = 2'd3;

    // Formula constants.
    localparam word32_t TEMP_ROUND     = 32'd128;
    localparam word32_t TEMP_SCALE     = 32'd5;
    localparam word64_t FINE_OFFSET    = 64'd128000;
    localparam word64_t RAW_FULL_SCALE = 64'd1048576;
    localparam word64_t PRESS_SCALE    = 64'd3125;
    localparam word64_t P1_BIAS        = 64'h0000_8000_0000_0000;

    // Sign-extend a 16-bit calibration word to 64 bits.
    function automatic word64_t sext16(input logic [15:0] v);
        sext16 = {{48{v[15]}}, v};
    endfunction

endpackage

// ===== hw/rtl/btpc_dly.sv =====
// Enabled shift line that carries side data along the pipeline.
module btpc_dly #(
    parameter int W     = 1,
    parameter int DEPTH = 1
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    logic [W-1:0] tap_reg [DEPTH];

    // Shift one place on every enabled cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                tap_reg[i] <= '0;
            end
        end
        else if (en)
        begin
            tap_reg[0] <= d;
            for (int i = 1; i < DEPTH; i++)
            begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign q = tap_reg[DEPTH-1];

endmodule

// ===== hw/rtl/btpc_mul64.sv =====
// Two-stage multiplier that gives the low 64 bits of a 64 by 64 product.
module btpc_mul64 (
    input  logic             clk,
    input  logic             en,
    input  btpc_pkg::word64_t a,
    input  btpc_pkg::word64_t b,
    output btpc_pkg::word64_t prod
);

    logic [63:0] ll_reg;
    logic [31:0] lh_reg;
    logic [31:0] hl_reg;
    logic [63:0] prod_reg;
    logic [63:0] ll_next;
    logic [31:0] lh_next;
    logic [31:0] hl_next;
    logic [31:0] cross_sum;

    // Partial products; the high by high term falls outside 64 bits.
    always_comb
    begin
        ll_next   = {32'd0, a[31:0]} * {32'd0, b[31:0]};
        lh_next   = a[31:0] * b[63:32];
        hl_next   = a[63:32] * b[31:0];
        cross_sum = lh_reg + hl_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ll_reg   <= ll_next;
            lh_reg   <= lh_next;
            hl_reg   <= hl_next;
            prod_reg <= ll_reg + {cross_sum, 32'd0};
        end
    end

    assign prod = prod_reg;

endmodule

// ===== hw/rtl/btpc_div.sv =====
// Unsigned restoring divider, one quotient bit per pipeline stage.
module btpc_div (
    input  logic             clk,
    input  logic             en,
    input  btpc_pkg::word64_t dividend,
    input  btpc_pkg::word64_t divisor,
    output btpc_pkg::word64_t quotient
);

    localparam int STAGES = 64;

    logic [63:0] rem_reg  [STAGES];
    logic [63:0] quo_reg  [STAGES];
    logic [63:0] dvs_reg  [STAGES];
    logic [63:0] rem_next [STAGES];
    logic [63:0] quo_next [STAGES];
    logic [63:0] dvs_next [STAGES];

    // Each stage shifts in one dividend bit and tries a subtraction.
    always_comb
    begin
        logic [63:0] src_rem;
        logic [63:0] src_quo;
        logic [63:0] src_dvs;
        logic [64:0] trial;
        logic        ge;
        for (int i = 0; i < STAGES; i++)
        begin
            if (i == 0)
            begin
                src_rem = '0;
                src_quo = dividend;
                src_dvs = divisor;
            end
            else
            begin
                src_rem = rem_reg[i-1];
                src_quo = quo_reg[i-1];
                src_dvs = dvs_reg[i-1];
            end
            trial       = {src_rem, src_quo[63]};
            ge          = (trial >= {1'b0, src_dvs});
            rem_next[i] = ge ? 64'(trial - {1'b0, src_dvs}) : trial[63:0];
            quo_next[i] = {src_quo[62:0], ge};
            dvs_next[i] = src_dvs;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < STAGES; i++)
            begin
                rem_reg[i] <= rem_next[i];
                quo_reg[i] <= quo_next[i];
                dvs_reg[i] <= dvs_next[i];
            end
        end
    end

    assign quotient = quo_reg[STAGES-1];

endmodule

// ===== hw/rtl/btpc_temp.sv =====
// Temperature path: fine temperature and saturated hundredths of a degree.
module btpc_temp (
    input  logic        clk,
    input  logic        en,
    input  logic [19:0] temperature_sample,
    input  logic [47:0] temp_cal,
    output logic [31:0] fine_early,
    output logic [31:0] fine_late,
    output logic [15:0] hundredths
);

    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] t3;
    logic [31:0] ain_reg, d_reg, pa_reg, pdd_reg, a_reg, e_reg, fine_reg, fine_d_reg;
    logic [15:0] hund_reg;
    logic [31:0] ain_next, d_next, e_next, fine_next, scaled, tr;
    logic [15:0] hund_next;

    assign t1 = {16'd0, temp_cal[15:0]};
    assign t2 = 32'(btpc_pkg::sext16(temp_cal[31:16]));
    assign t3 = 32'(btpc_pkg::sext16(temp_cal[47:32]));

    // Datapath arithmetic wraps at 32 bits; right shifts are arithmetic.
    always_comb
    begin
        ain_next  = {15'd0, temperature_sample[19:3]} - {t1[30:0], 1'b0};
        d_next    = {16'd0, temperature_sample[19:4]} - t1;
        e_next    = 32'($signed(pdd_reg) >>> 12) * t3;
        fine_next = a_reg + 32'($signed(e_reg) >>> 14);
        scaled    = fine_reg * btpc_pkg::TEMP_SCALE + btpc_pkg::TEMP_ROUND;
        tr        = 32'($signed(scaled) >>> 8);
        if (!tr[31] && tr[30:15] != 16'd0)
        begin
            hund_next = 16'h7fff;
        end
        else if (tr[31] && tr[30:15] != 16'hffff)
        begin
            hund_next = 16'h8000;
        end
        else
        begin
            hund_next = tr[15:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ain_reg    <= ain_next;
            d_reg      <= d_next;
            pa_reg     <= ain_reg * t2;
            pdd_reg    <= d_reg * d_reg;
            a_reg      <= 32'($signed(pa_reg) >>> 11);
            e_reg      <= e_next;
            fine_reg   <= fine_next;
            fine_d_reg <= fine_reg;
            hund_reg   <= hund_next;
        end
    end

    assign fine_early = fine_reg;
    assign fine_late  = fine_d_reg;
    assign hundredths = hund_reg;

endmodule

// ===== hw/rtl/baro_temp_pressure_compensation.sv =====
// Throughput: one transfer per cycle; the whole pipeline holds while a result
// waits under out_stall, and the 64-stage divider sets the depth.
// Reset clears the valid line, the delay lines and all four calibration registers
// to zero; other datapath registers are not reset.
`include "baro_temp_pressure_compensation_assert.svh"
module baro_temp_pressure_compensation (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [19:0] pressure_sample,
    input  logic [19:0] temperature_sample,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] fine_temperature,
    output logic [15:0] temperature_hundredths,
    output logic [31:0] pressure_q24_8,
    output logic        pressure_invalid
);

    localparam int LAT_COEF  = 10;
    localparam int LAT_SIGN  = 15;
    localparam int LAT_QUOT  = 79;
    localparam int LAT_TOTAL = 86;
    localparam int LAT_TEMP  = 5;

    logic [47:0] temp_cal_reg;
    logic [63:0] cal_low_reg;
    logic [63:0] cal_high_reg;
    logic [15:0] cal_last_reg;
    logic        en;
    logic        valid_tail;

    // Calibration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_cal_reg <= '0;
            cal_low_reg  <= '0;
            cal_high_reg <= '0;
            cal_last_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                btpc_pkg::CFG_TEMP_CAL:       temp_cal_reg <= cfg_data[47:0];
                btpc_pkg::CFG_PRESS_CAL_LOW:  cal_low_reg  <= cfg_data;
                btpc_pkg::CFG_PRESS_CAL_HIGH: cal_high_reg <= cfg_data;
                btpc_pkg::CFG_PRESS_CAL_LAST: cal_last_reg <= cfg_data[15:0];
                default:                      cal_last_reg <= cal_last_reg;
            endcase
        end
    end

    // The pipeline advances unless a finished result is held.
    assign en        = !(out_valid && out_stall);
    assign in_stall  = !en;
    assign out_valid = valid_tail;

    btpc_dly #(.W(1), .DEPTH(LAT_TOTAL)) u_valid (
        .clk(clk), .rst_n(rst_n), .en(en), .d(in_valid), .q(valid_tail)
    );

    // Calibration words.
    btpc_pkg::word64_t p1, p2, p3, p4, p5, p6, p7, p8, p9;
    assign p1 = {48'd0, cal_low_reg[15:0]};
    assign p2 = btpc_pkg::sext16(cal_low_reg[31:16]);
    assign p3 = btpc_pkg::sext16(cal_low_reg[47:32]);
    assign p4 = btpc_pkg::sext16(cal_low_reg[63:48]);
    assign p5 = btpc_pkg::sext16(cal_high_reg[15:0]);
    assign p6 = btpc_pkg::sext16(cal_high_reg[31:16]);
    assign p7 = btpc_pkg::sext16(cal_high_reg[47:32]);
    assign p8 = btpc_pkg::sext16(cal_high_reg[63:48]);
    assign p9 = btpc_pkg::sext16(cal_last_reg);

    // Temperature path.
    logic [31:0] fine_early, fine_late;
    logic [15:0] hund;
    btpc_temp u_temp (
        .clk(clk), .en(en), .temperature_sample(temperature_sample),
        .temp_cal(temp_cal_reg), .fine_early(fine_early), .fine_late(fine_late),
        .hundredths(hund)
    );

    // Temperature results wait for the pressure path.
    logic [47:0] temp_out;
    btpc_dly #(.W(48), .DEPTH(LAT_TOTAL - LAT_TEMP)) u_temp_dly (
        .clk(clk), .rst_n(rst_n), .en(en), .d({fine_late, hund}), .q(temp_out)
    );
    assign fine_temperature       = temp_out[47:16];
    assign temperature_hundredths = temp_out[15:0];

    // Raw pressure follows to where the dividend is formed.
    logic [19:0] rawp_d;
    btpc_dly #(.W(20), .DEPTH(LAT_COEF)) u_rawp_dly (
        .clk(clk), .rst_n(rst_n), .en(en), .d(pressure_sample), .q(rawp_d)
    );

    // Offset fine temperature.
    logic [63:0] v1_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v1_reg <= {{32{fine_early[31]}}, fine_early} - btpc_pkg::FINE_OFFSET;
        end
    end

    // First products of the offset temperature.
    btpc_pkg::word64_t sq, v1p5, v1p2, sq6, sq3, v1p5_d, v1p2_d;
    btpc_mul64 u_mul_sq  (.clk(clk), .en(en), .a(v1_reg), .b(v1_reg), .prod(sq));
    btpc_mul64 u_mul_v5  (.clk(clk), .en(en), .a(v1_reg), .b(p5), .prod(v1p5));
    btpc_mul64 u_mul_v2  (.clk(clk), .en(en), .a(v1_reg), .b(p2), .prod(v1p2));
    btpc_mul64 u_mul_sq6 (.clk(clk), .en(en), .a(sq), .b(p6), .prod(sq6));
    btpc_mul64 u_mul_sq3 (.clk(clk), .en(en), .a(sq), .b(p3), .prod(sq3));
    btpc_dly #(.W(128), .DEPTH(2)) u_lin_dly (
        .clk(clk), .rst_n(rst_n), .en(en), .d({v1p5, v1p2}), .q({v1p5_d, v1p2_d})
    );

    // Sums for the two pressure coefficients, then the bias and dividend terms.
    logic [63:0] v2_reg, v1b_reg, x_reg, n_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v2_reg  <= sq6 + (v1p5_d << 17) + (p4 << 35);
            v1b_reg <= 64'($signed(sq3) >>> 8) + (v1p2_d << 12);
            x_reg   <= btpc_pkg::P1_BIAS + v1b_reg;
            n_reg   <= ((btpc_pkg::RAW_FULL_SCALE - {44'd0, rawp_d}) << 31) - v2_reg;
        end
    end

    btpc_pkg::word64_t xp1, n3125;
    btpc_mul64 u_mul_p1 (.clk(clk), .en(en), .a(x_reg), .b(p1), .prod(xp1));
    btpc_mul64 u_mul_sc (.clk(clk), .en(en), .a(n_reg), .b(btpc_pkg::PRESS_SCALE),
        .prod(n3125));

    // Divisor and dividend, then operand magnitudes, the quotient sign and the zero-divisor flag.
    logic [63:0] dvs_reg, dvd_reg, mag_dvd_reg, mag_dvs_reg;
    logic        neg_reg, inv_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dvs_reg     <= 64'($signed(xp1) >>> 33);
            dvd_reg     <= n3125;
            mag_dvd_reg <= dvd_reg[63] ? 64'(-dvd_reg) : dvd_reg;
            mag_dvs_reg <= dvs_reg[63] ? 64'(-dvs_reg) : dvs_reg;
            neg_reg     <= dvd_reg[63] ^ dvs_reg[63];
            inv_reg     <= (dvs_reg == 64'd0);
        end
    end

    btpc_pkg::word64_t quo;
    btpc_div u_div (
        .clk(clk), .en(en), .dividend(mag_dvd_reg), .divisor(mag_dvs_reg),
        .quotient(quo)
    );

    logic neg_d;
    btpc_dly #(.W(1), .DEPTH(LAT_QUOT - LAT_SIGN)) u_neg_dly (
        .clk(clk), .rst_n(rst_n), .en(en), .d(neg_reg), .q(neg_d)
    );
    logic inv_d;
    btpc_dly #(.W(1), .DEPTH(LAT_TOTAL - 1 - LAT_SIGN)) u_inv_dly (
        .clk(clk), .rst_n(rst_n), .en(en), .d(inv_reg), .q(inv_d)
    );

    // Signed quotient.
    logic [63:0] p_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= neg_d ? 64'(-quo) : quo;
        end
    end

    // Second-order correction products.
    btpc_pkg::word64_t ps, pss, pp, w1m, w2m, p_d;
    assign ps = 64'($signed(p_reg) >>> 13);
    btpc_mul64 u_mul_pss (.clk(clk), .en(en), .a(ps), .b(ps), .prod(pss));
    btpc_mul64 u_mul_pp  (.clk(clk), .en(en), .a(p_reg), .b(p_reg), .prod(pp));
    btpc_mul64 u_mul_w1  (.clk(clk), .en(en), .a(pss), .b(p9), .prod(w1m));
    btpc_mul64 u_mul_w2  (.clk(clk), .en(en), .a(pp), .b(p8), .prod(w2m));
    btpc_dly #(.W(64), .DEPTH(4)) u_p_dly (
        .clk(clk), .rst_n(rst_n), .en(en), .d(p_reg), .q(p_d)
    );

    // Final sum, offset and clamp into Q24.8.
    logic [63:0] s_reg;
    logic [63:0] r;
    logic [31:0] pq_reg, pq_next;
    logic        inv_out_reg;
    always_comb
    begin
        r = 64'($signed(s_reg) >>> 8) + (p7 << 4);
        if (inv_d || r[63])
        begin
            pq_next = 32'd0;
        end
        else if (r[62:32] != 31'd0)
        begin
            pq_next = 32'hffff_ffff;
        end
        else
        begin
            pq_next = r[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg       <= p_d + 64'($signed(w1m) >>> 25) + 64'($signed(w2m) >>> 19);
            pq_reg      <= pq_next;
            inv_out_reg <= inv_d;
        end
    end

    assign pressure_q24_8   = pq_reg;
    assign pressure_invalid = inv_out_reg;

    `BTPC_ASSERT_NOW(a_invalid_zero, out_valid && pressure_invalid, pressure_q24_8 == 32'd0)
    `BTPC_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall)
    `BTPC_ASSERT_NEXT(a_held_result, out_valid && out_stall, out_valid)

endmodule
